>>> sv/positional_array_list_macros.svh
// ----------------------------------------------------------------------------
// positional_array_list_macros.svh
// assertion macros for the positional array list rtl
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every rising edge outside of reset
`define PAL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// property checked on every rising edge, reset included
`define PAL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define PAL_ASSERT(lbl, clk, rst, prop)
`define PAL_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> sv/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// sizes, codes and shared types of the positional array list
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
  localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  // sequencer to store access
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [VALUE_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  // finished result of one transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  count;
  } result_t;

endpackage

>>> sv/pal_ram.sv
// ----------------------------------------------------------------------------
// pal_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pal_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/pal_ctrl.sv
// ----------------------------------------------------------------------------
// pal_ctrl
// request sequencer: range checks, shift and scan walks, element count
// ----------------------------------------------------------------------------
module pal_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pal_pkg::OP_W-1:0]        op,
  input  logic [pal_pkg::VALUE_W-1:0]     value,
  input  logic [pal_pkg::POS_W-1:0]       position,
  output pal_pkg::mem_req_t               mem_req,
  input  logic [pal_pkg::VALUE_W-1:0]     mem_rdata,
  output logic                            res_valid,
  input  logic                            res_ready,
  output pal_pkg::result_t                res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SCAN,
    S_DRAIN,
    S_PUT,
    S_FINISH
  } state_t;

  state_t                          state;
  logic [pal_pkg::CNT_W-1:0]       cnt;
  logic [pal_pkg::CNT_W-1:0]       cnt_new;
  logic [pal_pkg::OP_W-1:0]        op_q;
  logic [pal_pkg::VALUE_W-1:0]     val_q;
  logic [pal_pkg::IDX_W-1:0]       pos_q;
  logic [pal_pkg::IDX_W-1:0]       rd_idx;
  logic [pal_pkg::IDX_W-1:0]       last_idx;
  logic [pal_pkg::STATUS_W-1:0]    status_q;
  logic                            found_q;
  logic                            wb_pend;
  logic [pal_pkg::IDX_W-1:0]       wb_addr;
  logic                            cmp_pend;

  logic [pal_pkg::CMP_W-1:0]       pos_ext;
  logic [pal_pkg::CMP_W-1:0]       cnt_ext;
  logic [pal_pkg::CNT_W-1:0]       cnt_inc;
  logic [pal_pkg::CNT_W-1:0]       cnt_dec;
  logic                            full;
  logic                            empty;

  assign pos_ext = pal_pkg::CMP_W'(position);
  assign cnt_ext = pal_pkg::CMP_W'(cnt);
  assign cnt_inc = cnt + pal_pkg::CNT_W'(1);
  assign cnt_dec = cnt - pal_pkg::CNT_W'(1);
  assign full    = (cnt == pal_pkg::CNT_W'(pal_pkg::CAPACITY));
  assign empty   = (cnt == '0);

  assign in_ready   = (state == S_IDLE);
  assign res_valid  = (state == S_FINISH);
  assign res.status = status_q;
  assign res.found  = found_q;
  assign res.count  = pal_pkg::COUNT_W'(cnt_new);

  // store access: pending shift write-back first, then single writes
  always_comb begin
    mem_req.re    = (state == S_SHIFT_UP) || (state == S_SHIFT_DN) || (state == S_SCAN);
    mem_req.raddr = rd_idx;
    mem_req.we    = 1'b0;
    mem_req.waddr = pal_pkg::IDX_W'(position);
    mem_req.wdata = value;
    if (wb_pend) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = wb_addr;
      mem_req.wdata = mem_rdata;
    end else if (state == S_PUT) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = pos_q;
      mem_req.wdata = val_q;
    end else if (state == S_IDLE && in_valid) begin
      unique case (op)
        pal_pkg::OP_APPEND: begin
          mem_req.we    = !full;
          mem_req.waddr = pal_pkg::IDX_W'(cnt);
        end
        pal_pkg::OP_INSERT:  mem_req.we = !full && (pos_ext == cnt_ext);
        pal_pkg::OP_REPLACE: mem_req.we = (pos_ext < cnt_ext);
        default:             mem_req.we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      wb_pend  <= 1'b0;
      cmp_pend <= 1'b0;
    end else begin
      wb_pend  <= 1'b0;
      cmp_pend <= 1'b0;
      if (cmp_pend && (mem_rdata == val_q)) begin
        found_q <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q     <= op;
            val_q    <= value;
            pos_q    <= pal_pkg::IDX_W'(position);
            status_q <= pal_pkg::ST_OK;
            found_q  <= 1'b0;
            cnt_new  <= cnt;
            state    <= S_FINISH;
            unique case (op)
              pal_pkg::OP_APPEND: begin
                if (full) begin
                  status_q <= pal_pkg::ST_FULL;
                end else begin
                  cnt_new <= cnt_inc;
                end
              end
              pal_pkg::OP_INSERT: begin
                if (full) begin
                  status_q <= pal_pkg::ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                  status_q <= pal_pkg::ST_BADPOS;
                end else begin
                  cnt_new <= cnt_inc;
                  if (pos_ext != cnt_ext) begin
                    rd_idx   <= pal_pkg::IDX_W'(cnt_dec);
                    last_idx <= pal_pkg::IDX_W'(position);
                    state    <= S_SHIFT_UP;
                  end
                end
              end
              pal_pkg::OP_DELETE: begin
                if (empty) begin
                  status_q <= pal_pkg::ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                  status_q <= pal_pkg::ST_BADPOS;
                end else begin
                  cnt_new <= cnt_dec;
                  if (pos_ext != pal_pkg::CMP_W'(cnt_dec)) begin
                    rd_idx   <= pal_pkg::IDX_W'(position) + pal_pkg::IDX_W'(1);
                    last_idx <= pal_pkg::IDX_W'(cnt_dec);
                    state    <= S_SHIFT_DN;
                  end
                end
              end
              pal_pkg::OP_REPLACE: begin
                if (pos_ext >= cnt_ext) begin
                  status_q <= pal_pkg::ST_BADPOS;
                end
              end
              pal_pkg::OP_SEARCH: begin
                if (!empty) begin
                  rd_idx   <= '0;
                  last_idx <= pal_pkg::IDX_W'(cnt_dec);
                  state    <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SHIFT_UP: begin
          wb_pend <= 1'b1;
          wb_addr <= rd_idx + pal_pkg::IDX_W'(1);
          rd_idx  <= rd_idx - pal_pkg::IDX_W'(1);
          if (rd_idx == last_idx) begin
            state <= S_DRAIN;
          end
        end
        S_SHIFT_DN: begin
          wb_pend <= 1'b1;
          wb_addr <= rd_idx - pal_pkg::IDX_W'(1);
          rd_idx  <= rd_idx + pal_pkg::IDX_W'(1);
          if (rd_idx == last_idx) begin
            state <= S_DRAIN;
          end
        end
        S_SCAN: begin
          cmp_pend <= 1'b1;
          rd_idx   <= rd_idx + pal_pkg::IDX_W'(1);
          if (rd_idx == last_idx) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= (op_q == pal_pkg::OP_INSERT) ? S_PUT : S_FINISH;
        end
        S_PUT: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ready) begin
            cnt   <= cnt_new;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list
// bounded ordered list of signed 32-bit words with positional edit and search
// ----------------------------------------------------------------------------
// The list holds up to 64 words in a single-port-read, single-port-write
// ram plus an element count. Every transaction yields one result with a
// status, a found flag and the count afterward. One transaction is worked
// on at a time; the ram's one read and one write port set the pace, one
// entry moved or compared per cycle. Insert at position p moves count-p
// entries up, then writes the new word; insert at the end writes it
// directly. Delete at p moves the entries above p down, and deleting the
// last entry moves none. Search walks the whole list with no early exit.
// No clearing pass: the store is only read below the count, so its
// power-up contents are never seen. A result waits in an output
// register, so input can be taken again while the previous result is
// still pending downstream.
// ----------------------------------------------------------------------------
`include "positional_array_list_macros.svh"

module positional_array_list (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pal_pkg::OP_W-1:0]           op,
  input  logic signed [pal_pkg::VALUE_W-1:0] value,
  input  logic [pal_pkg::POS_W-1:0]          position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pal_pkg::STATUS_W-1:0]       status,
  output logic                               found,
  output logic [pal_pkg::COUNT_W-1:0]        count
);

  pal_pkg::mem_req_t             mem_req;
  logic [pal_pkg::VALUE_W-1:0]   mem_rdata;
  logic                          res_valid;
  logic                          res_ready;
  pal_pkg::result_t              res;
  logic                          out_at_cap;
  logic                          out_ok_nonempty;

  // list storage
  pal_ram #(
    .DEPTH (pal_pkg::CAPACITY),
    .WIDTH (pal_pkg::VALUE_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // request sequencer and element count
  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .value     (value),
    .position  (position),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: a finished result moves in when the slot is free
  // or is being drained in the same cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status <= res.status;
      found  <= res.found;
      count  <= res.count;
    end
  end

  // result flags watched by the checks below
  assign out_at_cap      = (count == pal_pkg::COUNT_W'(pal_pkg::CAPACITY));
  assign out_ok_nonempty = (status == pal_pkg::ST_OK) && (count != '0);

  // an accepted transaction always leaves the idle state in the next cycle
  `PAL_ASSERT(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)

  // a full rejection reports a list at capacity
  `PAL_ASSERT(a_full_count, clk, rst, (out_valid && status == pal_pkg::ST_FULL) |-> out_at_cap)

  // a hit can only come from a successful search of a non-empty list
  `PAL_ASSERT(a_found_ok, clk, rst, (out_valid && found) |-> out_ok_nonempty)

  // reset leaves no result pending
  `PAL_ASSERT_ALWAYS(a_reset_clear, clk, $past(rst) |-> !out_valid)

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the positional array list: a queue of requests
// feeds a valid/ready driver, a clocked monitor predicts every accepted
// transaction against a local copy of the list and checks each result
// ----------------------------------------------------------------------------
module tb;

  // op codes the block ignores
  localparam logic [pal_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [pal_pkg::OP_W-1:0] OP_UNUSED_MID   = 3'd6;
  localparam logic [pal_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  localparam int RANDOM_ITEMS = 1250;
  localparam int PHASE_LEN    = 160;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 1000000;

  // list copies: SHADOW steers the generator, LIVE predicts at acceptance
  localparam int SHADOW = 0;
  localparam int LIVE   = 1;

  typedef struct packed {
    logic [pal_pkg::OP_W-1:0]           op;
    logic signed [pal_pkg::VALUE_W-1:0] value;
    logic [pal_pkg::POS_W-1:0]          position;
  } request_t;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  logic [pal_pkg::OP_W-1:0]           op;
  logic signed [pal_pkg::VALUE_W-1:0] value;
  logic [pal_pkg::POS_W-1:0]          position;
  logic                               out_valid;
  logic                               out_ready;
  logic [pal_pkg::STATUS_W-1:0]       status;
  logic                               found;
  logic [pal_pkg::COUNT_W-1:0]        count;

  positional_array_list dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .value     (value),
    .position  (position),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .found     (found),
    .count     (count)
  );

  // two copies of the list contents and length
  logic signed [pal_pkg::VALUE_W-1:0] list_words [2][pal_pkg::CAPACITY];
  int                                 list_len   [2];

  request_t          request_queue[$];
  pal_pkg::result_t  pending_results[$];

  int issued_count   = 0;
  int accepted_count = 0;
  int total_requests = 0;
  int cycle_count    = 0;
  int error_count    = 0;
  int checked_count  = 0;
  int status_tally [4];
  int found_tally    = 0;
  int peak_len       = 0;
  int in_gap_left    = 0;
  int out_stall_left = 0;

  // --------------------------------------------------------------------------
  // clock, cycle counter and watchdog
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // list behavior: applies one request to copy sel and returns its result
  // --------------------------------------------------------------------------
  function automatic pal_pkg::result_t apply_list_request(input int sel, input request_t rq);
    pal_pkg::result_t r;
    int               n;
    int               p;
    n = list_len[sel];
    p = int'(rq.position);
    r.status = pal_pkg::ST_OK;
    r.found  = 1'b0;
    case (rq.op)
      pal_pkg::OP_APPEND: begin
        if (n >= pal_pkg::CAPACITY) begin
          r.status = pal_pkg::ST_FULL;
        end else begin
          list_words[sel][n] = rq.value;
          n++;
        end
      end
      pal_pkg::OP_INSERT: begin
        // full is checked ahead of the position
        if (n >= pal_pkg::CAPACITY) begin
          r.status = pal_pkg::ST_FULL;
        end else if (p > n) begin
          r.status = pal_pkg::ST_BADPOS;
        end else begin
          for (int i = n; i > p; i--) list_words[sel][i] = list_words[sel][i-1];
          list_words[sel][p] = rq.value;
          n++;
        end
      end
      pal_pkg::OP_DELETE: begin
        // empty is checked ahead of the position
        if (n == 0) begin
          r.status = pal_pkg::ST_EMPTY;
        end else if (p >= n) begin
          r.status = pal_pkg::ST_BADPOS;
        end else begin
          for (int i = p; i + 1 < n; i++) list_words[sel][i] = list_words[sel][i+1];
          n--;
        end
      end
      pal_pkg::OP_REPLACE: begin
        if (p >= n) r.status = pal_pkg::ST_BADPOS;
        else list_words[sel][p] = rq.value;
      end
      pal_pkg::OP_SEARCH: begin
        for (int i = 0; i < n; i++) begin
          if (list_words[sel][i] == rq.value) r.found = 1'b1;
        end
      end
      default: ;
    endcase
    list_len[sel] = n;
    r.count = n[pal_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // idle length: mostly short, a few long, none during calm stretches
  function automatic int pick_gap();
    int r;
    if ((cycle_count % 3000) < 600) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // word to store, with the two's complement extremes now and then
  function automatic logic signed [pal_pkg::VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return {1'b1, {(pal_pkg::VALUE_W-1){1'b0}}};
    if (r < 10) return {1'b0, {(pal_pkg::VALUE_W-1){1'b1}}};
    if (r < 15) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  // position mostly inside [0, hi], edges favored, otherwise any 7-bit value
  function automatic logic [pal_pkg::POS_W-1:0] pick_position(input int hi);
    int r;
    r = $urandom_range(0, 99);
    if (hi < 0 || r >= 80)
      return pal_pkg::POS_W'($urandom_range(0, (1 << pal_pkg::POS_W) - 1));
    if (r < 10) return '0;
    if (r < 20) return hi[pal_pkg::POS_W-1:0];
    return pal_pkg::POS_W'($urandom_range(0, hi));
  endfunction

  task automatic queue_request(input logic [pal_pkg::OP_W-1:0] rq_op,
                               input logic signed [pal_pkg::VALUE_W-1:0] rq_val,
                               input logic [pal_pkg::POS_W-1:0] rq_pos);
    request_t         rq;
    pal_pkg::result_t unused_res;
    rq.op       = rq_op;
    rq.value    = rq_val;
    rq.position = rq_pos;
    request_queue.push_back(rq);
    unused_res = apply_list_request(SHADOW, rq);
    total_requests++;
  endtask

  // --------------------------------------------------------------------------
  // driver: pulls requests from the queue, inputs change on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    request_t rq;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || accepted_count == issued_count) begin
      // slot is free: previous transaction taken or nothing was offered
      if (in_gap_left > 0) begin
        in_valid <= 1'b0;
        in_gap_left--;
      end else if (request_queue.size() > 0) begin
        rq = request_queue.pop_front();
        op       <= rq.op;
        value    <= rq.value;
        position <= rq.position;
        in_valid <= 1'b1;
        issued_count++;
        in_gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall_left > 0) begin
      out_ready <= 1'b0;
      out_stall_left--;
    end else begin
      out_ready <= 1'b1;
      out_stall_left = pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predicts on input transactions, checks result transactions
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    request_t         rq;
    pal_pkg::result_t exp_res;
    if (!rst) begin
      if (in_valid && in_ready) begin
        rq.op       = op;
        rq.value    = value;
        rq.position = position;
        pending_results.push_back(apply_list_request(LIVE, rq));
        if (list_len[LIVE] > peak_len) peak_len = list_len[LIVE];
        accepted_count <= accepted_count + 1;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected: status %0d found %0d count %0d",
                 status, found, count);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          checked_count++;
          status_tally[exp_res.status]++;
          if (exp_res.found) found_tally++;
          if (status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, status);
            error_count++;
          end
          if (found !== exp_res.found) begin
            $error("found: expected %0d, actual %0d", exp_res.found, found);
            error_count++;
          end
          if (count !== exp_res.count) begin
            $error("count: expected %0d, actual %0d", exp_res.count, count);
            error_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int                                 counted;
    int                                 phase;
    int                                 r;
    int                                 n;
    logic [pal_pkg::OP_W-1:0]           rop;
    logic signed [pal_pkg::VALUE_W-1:0] rval;

    rst       = 1'b1;
    in_valid  = 1'b0;
    out_ready = 1'b0;
    op        = '0;
    value     = '0;
    position  = '0;
    list_len[SHADOW] = 0;
    list_len[LIVE]   = 0;
    for (int i = 0; i < 4; i++) status_tally[i] = 0;

    // directed: empty list corners, field extremes, every op and unused codes
    queue_request(pal_pkg::OP_SEARCH,  32'sd5, 7'd0);       // search on empty
    queue_request(pal_pkg::OP_DELETE,  32'sd0, 7'd0);       // delete on empty
    queue_request(pal_pkg::OP_REPLACE, 32'sd1, 7'd0);       // replace on empty
    queue_request(pal_pkg::OP_INSERT,  32'sd2, 7'd1);       // insert past count
    queue_request(pal_pkg::OP_INSERT,  32'sd3, 7'd0);       // insert at count appends
    queue_request(pal_pkg::OP_APPEND,  {1'b0, {(pal_pkg::VALUE_W-1){1'b1}}}, 7'd0);
    queue_request(pal_pkg::OP_APPEND,  {1'b1, {(pal_pkg::VALUE_W-1){1'b0}}}, 7'd127);
    queue_request(pal_pkg::OP_INSERT,  -32'sd1, 7'd3);      // insert at end
    queue_request(pal_pkg::OP_INSERT,  32'sd9, 7'd0);       // insert at head
    queue_request(pal_pkg::OP_SEARCH,  {1'b1, {(pal_pkg::VALUE_W-1){1'b0}}}, 7'd0);
    queue_request(pal_pkg::OP_SEARCH,  32'sd12345, 7'd0);   // key absent
    queue_request(pal_pkg::OP_REPLACE, 32'sd7, 7'd0);
    queue_request(pal_pkg::OP_REPLACE, 32'sd8, 7'd4);       // last entry
    queue_request(pal_pkg::OP_REPLACE, 32'sd8, 7'd5);       // at count
    queue_request(pal_pkg::OP_DELETE,  32'sd0, 7'd5);       // at count
    queue_request(pal_pkg::OP_DELETE,  32'sd0, 7'd127);
    queue_request(pal_pkg::OP_DELETE,  32'sd0, 7'd4);       // last entry
    queue_request(pal_pkg::OP_DELETE,  32'sd0, 7'd1);       // middle
    queue_request(OP_UNUSED_FIRST, 32'sd1, 7'd0);
    queue_request(OP_UNUSED_MID, '1, 7'd127);
    queue_request(OP_UNUSED_LAST, 32'sd0, 7'd64);
    queue_request(pal_pkg::OP_SEARCH,  32'sd7, 7'd127);

    // random: phases that grow the list to full, drain it to empty, or churn
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      phase = (counted / PHASE_LEN) % 3;
      n     = list_len[SHADOW];
      r     = $urandom_range(0, 99);
      if (r < 3) begin
        queue_request(pal_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                      $urandom,
                      pal_pkg::POS_W'($urandom_range(0, (1 << pal_pkg::POS_W) - 1)));
      end else begin
        r = $urandom_range(0, 99);
        if (phase == 0) begin
          rop = (r < 45) ? pal_pkg::OP_APPEND : (r < 70) ? pal_pkg::OP_INSERT :
                (r < 80) ? pal_pkg::OP_DELETE : (r < 90) ? pal_pkg::OP_REPLACE :
                pal_pkg::OP_SEARCH;
        end else if (phase == 1) begin
          rop = (r < 15) ? pal_pkg::OP_APPEND : (r < 25) ? pal_pkg::OP_INSERT :
                (r < 70) ? pal_pkg::OP_DELETE : (r < 85) ? pal_pkg::OP_REPLACE :
                pal_pkg::OP_SEARCH;
        end else begin
          rop = (r < 25) ? pal_pkg::OP_APPEND : (r < 45) ? pal_pkg::OP_INSERT :
                (r < 65) ? pal_pkg::OP_DELETE : (r < 82) ? pal_pkg::OP_REPLACE :
                pal_pkg::OP_SEARCH;
        end
        rval = pick_value();
        // searches hit a stored word about half the time
        if (rop == pal_pkg::OP_SEARCH && n > 0 && $urandom_range(0, 1))
          rval = list_words[SHADOW][$urandom_range(0, n - 1)];
        queue_request(rop, rval, pick_position((rop == pal_pkg::OP_INSERT) ? n : n - 1));
        counted++;
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_count < total_requests || pending_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transactions checked over %0d cycles, list reached %0d of %0d entries",
             checked_count, cycle_count, peak_len, pal_pkg::CAPACITY);
    $display("status ok %0d, full %0d, bad position %0d, empty %0d; searches found %0d",
             status_tally[pal_pkg::ST_OK], status_tally[pal_pkg::ST_FULL],
             status_tally[pal_pkg::ST_BADPOS], status_tally[pal_pkg::ST_EMPTY],
             found_tally);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
